// File: rtl/sscl_pkg.sv
`default_nettype none

package sscl_pkg;

	localparam int unsigned POLL_W = 8;
	localparam int unsigned CLK_W = 14;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 14;

	localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 8'd50;
	localparam logic [CLK_W-1:0] CLOCK_LIMIT_RESET = 14'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_POLL_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_CLOCK_LIMIT = 2'd1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_WAIT     = 3'd1,
		PH_UPLOAD   = 3'd2,
		PH_DONE     = 3'd3,
		PH_ERROR    = 3'd4,
		PH_DISABLED = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		KIND_BEGIN   = 3'd0,
		KIND_POLL    = 3'd1,
		KIND_DATA    = 3'd2,
		KIND_FINISH  = 3'd3,
		KIND_DISABLE = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		FAULT_NONE    = 2'd0,
		FAULT_TIMEOUT = 2'd1,
		FAULT_REJECT  = 2'd2
	} fault_t;

	// One decoded item: the results it causes, described compactly.
	typedef struct packed {
		logic [2:0] rem;
		logic       clock_pulse;
		logic [7:0] shift;
		logic       prog_first;
		logic       prog_rest;
		phase_t     status;
		fault_t     fault;
		logic       online;
	} desc_t;

endpackage

`default_nettype wire

// File: rtl/sscl_step.sv
`default_nettype none

module sscl_step import sscl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            kind,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  init_level,
	input  wire logic                  done_level,
	input  wire logic                  desc_ready,
	output logic                       desc_valid,
	output desc_t                      desc
);

	logic              valid_s1;
	logic [2:0]        kind_s1;
	logic [7:0]        byte_s1;
	logic              init_s1;
	logic              done_s1;

	logic [POLL_W-1:0] poll_limit_q;
	logic [CLK_W-1:0]  clock_limit_q;
	phase_t            phase_q;
	logic [POLL_W-1:0] poll_count_q;
	logic [CLK_W-1:0]  clock_count_q;
	logic              prog_q;

	phase_t            phase_d;
	logic [POLL_W-1:0] poll_count_d;
	logic [CLK_W-1:0]  clock_count_d;
	logic              prog_d;
	logic [POLL_W-1:0] poll_inc;
	logic [CLK_W-1:0]  clock_inc;
	logic [POLL_W-1:0] poll_lim;
	logic [CLK_W-1:0]  clock_lim;
	logic              advance;

	assign in_stall = valid_s1 && !desc_ready;
	assign advance = valid_s1 && desc_ready;
	assign desc_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
			init_s1 <= init_level;
			done_s1 <= done_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
			clock_limit_q <= CLOCK_LIMIT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_INIT_POLL_LIMIT) begin
				poll_limit_q <= cfg_data[POLL_W-1:0];
			end
			if (cfg_index == REG_FINISH_CLOCK_LIMIT) begin
				clock_limit_q <= cfg_data[CLK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			poll_count_q <= '0;
			clock_count_q <= '0;
			prog_q <= 1'b1;
		end else if (advance) begin
			phase_q <= phase_d;
			poll_count_q <= poll_count_d;
			clock_count_q <= clock_count_d;
			prog_q <= prog_d;
		end
	end

	// A limit of zero behaves as a limit of one.
	assign poll_lim = (poll_limit_q == '0) ? POLL_W'(1) : poll_limit_q;
	assign clock_lim = (clock_limit_q == '0) ? CLK_W'(1) : clock_limit_q;
	assign poll_inc = poll_count_q + POLL_W'(1);
	assign clock_inc = clock_count_q + CLK_W'(1);

	always_comb begin
		phase_d = phase_q;
		poll_count_d = poll_count_q;
		clock_count_d = clock_count_q;
		prog_d = prog_q;
		desc.rem = 3'd0;
		desc.clock_pulse = 1'b0;
		desc.shift = 8'd0;
		desc.prog_first = prog_q;
		desc.prog_rest = prog_q;
		desc.fault = FAULT_REJECT;
		unique case (kind_t'(kind_s1))
			KIND_BEGIN: begin
				phase_d = PH_WAIT;
				poll_count_d = '0;
				clock_count_d = '0;
				prog_d = 1'b1;
				desc.rem = 3'd1;
				desc.prog_first = 1'b0;
				desc.prog_rest = 1'b1;
				desc.fault = FAULT_NONE;
			end
			KIND_POLL: begin
				if (phase_q == PH_WAIT) begin
					desc.fault = FAULT_NONE;
					if (init_s1) begin
						phase_d = PH_UPLOAD;
						clock_count_d = '0;
					end else if (poll_inc >= poll_lim) begin
						phase_d = PH_IDLE;
						poll_count_d = '0;
						desc.fault = FAULT_TIMEOUT;
					end else begin
						poll_count_d = poll_inc;
					end
				end
			end
			KIND_DATA: begin
				if (phase_q == PH_UPLOAD) begin
					desc.rem = 3'd7;
					desc.clock_pulse = 1'b1;
					desc.shift = byte_s1;
					desc.fault = FAULT_NONE;
				end
			end
			KIND_FINISH: begin
				if (phase_q == PH_UPLOAD) begin
					desc.clock_pulse = 1'b1;
					desc.fault = FAULT_NONE;
					if (done_s1) begin
						phase_d = PH_DONE;
					end else begin
						clock_count_d = clock_inc;
						if (clock_inc >= clock_lim) begin
							phase_d = PH_ERROR;
						end
					end
				end
			end
			KIND_DISABLE: begin
				prog_d = 1'b0;
				phase_d = PH_DISABLED;
				desc.prog_first = 1'b0;
				desc.prog_rest = 1'b0;
				desc.fault = FAULT_NONE;
			end
			default: begin
			end
		endcase
		desc.status = phase_d;
		desc.online = ((phase_d == PH_IDLE) || (phase_d == PH_DONE)) && done_s1;
	end

endmodule

`default_nettype wire

// File: rtl/sscl_emit.sv
`default_nettype none

module sscl_emit import sscl_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  desc_valid,
	output logic       desc_ready,
	input  wire desc_t desc,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic       clock_pulse,
	output logic       serial_bit,
	output logic       prog_level,
	output logic [2:0] status,
	output logic [1:0] fault,
	output logic       online,
	output logic       last
);

	logic  valid_q;
	desc_t cur_q;
	logic  prog_q;
	logic  taken;

	assign taken = valid_q && !out_stall;
	assign last = (cur_q.rem == 3'd0);
	assign desc_ready = !valid_q || (taken && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (desc_ready) begin
			valid_q <= desc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (desc_ready && desc_valid) begin
			cur_q <= desc;
			prog_q <= desc.prog_first;
		end else if (taken && !last) begin
			cur_q.rem <= cur_q.rem - 3'd1;
			cur_q.shift <= {cur_q.shift[6:0], 1'b0};
			prog_q <= cur_q.prog_rest;
		end
	end

	assign out_valid = valid_q;
	assign clock_pulse = cur_q.clock_pulse;
	assign serial_bit = cur_q.shift[7];
	assign prog_level = prog_q;
	assign status = cur_q.status;
	assign fault = cur_q.fault;
	assign online = cur_q.online;

endmodule

`default_nettype wire

// File: rtl/fpga_slave_serial_config_loader_unit.sv
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_we              cfg_index, cfg_data
// in        in         in_valid/in_stall   kind, data_byte, init_level, done_level
// out       out        out_valid/out_stall clock_pulse, serial_bit, prog_level,
//                                          status, fault, online, last
//
// An item is held in the input register, where the loader state is updated as it moves on,
// and then leaves from the result register one transfer per cycle unless out_stall holds it.
// A data byte in the upload phase yields 8 transfers of output, a begin item 2, every other item 1.
// The output serializer sets the sustained rate; one new item can wait in the input register while results wait.
// Reset restores both limit registers and puts the loader in idle with PROG released.
`default_nettype none

module fpga_slave_serial_config_loader_unit import sscl_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [2:0]            kind,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  init_level,
	input  wire logic                  done_level,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       clock_pulse,
	output logic                       serial_bit,
	output logic                       prog_level,
	output logic [2:0]                 status,
	output logic [1:0]                 fault,
	output logic                       online,
	output logic                       last
);

	logic  desc_valid;
	logic  desc_ready;
	desc_t desc;

	sscl_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.init_level (init_level),
		.done_level (done_level),
		.desc_ready (desc_ready),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	sscl_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_valid  (desc_valid),
		.desc_ready  (desc_ready),
		.desc        (desc),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.clock_pulse (clock_pulse),
		.serial_bit  (serial_bit),
		.prog_level  (prog_level),
		.status      (status),
		.fault       (fault),
		.online      (online),
		.last        (last)
	);

endmodule

`default_nettype wire
